/* rtl/atoc_pkg.sv */
// ----------------------------------------------------------------------------
// atoc_pkg
// Shared constants, command and verdict codes, and the control structs that
// pass between the fetch controller and the geometry engine.
// ----------------------------------------------------------------------------
package atoc_pkg;

  localparam int COORD_BITS    = 20;
  localparam int IDX_BITS      = 12;
  localparam int NUM_POINTS    = 4096;
  localparam int NUM_TRIANGLES = 4096;

  // Store word layouts: point {z, y, x}, triangle {c, b, a}
  localparam int PT_W  = 3 * COORD_BITS;
  localparam int TRI_W = 3 * IDX_BITS;

  // Command codes
  localparam logic [1:0] CMD_LOAD_POINT = 2'd0;
  localparam logic [1:0] CMD_LOAD_TRI   = 2'd1;
  localparam logic [1:0] CMD_COMPARE    = 2'd2;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE     = 2'd0;
  localparam logic [1:0] VERDICT_OPPOSITE = 2'd1;
  localparam logic [1:0] VERDICT_SAME     = 2'd2;

  // Controller to geometry engine
  typedef struct packed {
    logic       start;
    logic       take;
    logic       hit;
    logic [1:0] ci;
    logic [1:0] cj;
  } atoc_cmd_t;

  // Geometry engine to controller
  typedef struct packed {
    logic       done;
    logic [1:0] verdict;
  } atoc_sts_t;

endpackage

/* rtl/atoc_geom.sv */
// ----------------------------------------------------------------------------
// atoc_geom
// Geometry engine: builds edge vectors from the six fetched points, then runs
// every cross and dot product through one shared signed multiplier followed by
// a wide accumulator, one product issued per cycle.
// ----------------------------------------------------------------------------
module atoc_geom import atoc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  atoc_cmd_t       cmd,
  input  logic [PT_W-1:0] p1a,
  input  logic [PT_W-1:0] p1b,
  input  logic [PT_W-1:0] p1c,
  input  logic [PT_W-1:0] p2a,
  input  logic [PT_W-1:0] p2b,
  input  logic [PT_W-1:0] p2c,
  output atoc_sts_t       sts
);

  // Value widths: edge, centroid sum, normal, edge-based normal
  localparam int EW   = COORD_BITS + 1;
  localparam int MW   = COORD_BITS + 2;
  localparam int NW   = 2 * EW + 1;
  localparam int UW   = MW + EW + 1;
  localparam int HB   = (UW + 1) / 2;
  localparam int OPW  = HB + 2;
  localparam int PW   = 2 * OPW;
  localparam int ACCW = 2 * UW + 4;

  // Product groups
  localparam logic [1:0] G_CHK = 2'd0;  // parallel edge test
  localparam logic [1:0] G_NRM = 2'd1;  // winding normals
  localparam logic [1:0] G_UCR = 2'd2;  // edge-based normals
  localparam logic [1:0] G_DOT = 2'd3;  // final dot products, split in halves

  // Engine states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  function automatic logic signed [EW-1:0] ce(input logic [3*EW-1:0] v,
                                              input logic [1:0] i);
    case (i)
      2'd0:    ce = v[EW-1:0];
      2'd1:    ce = v[2*EW-1:EW];
      default: ce = v[3*EW-1:2*EW];
    endcase
  endfunction

  function automatic logic signed [MW-1:0] cm(input logic [3*MW-1:0] v,
                                              input logic [1:0] i);
    case (i)
      2'd0:    cm = v[MW-1:0];
      2'd1:    cm = v[2*MW-1:MW];
      default: cm = v[3*MW-1:2*MW];
    endcase
  endfunction

  function automatic logic [NW-1:0] cn(input logic [3*NW-1:0] v, input logic [1:0] i);
    case (i)
      2'd0:    cn = v[NW-1:0];
      2'd1:    cn = v[2*NW-1:NW];
      default: cn = v[3*NW-1:2*NW];
    endcase
  endfunction

  function automatic logic [UW-1:0] cu(input logic [3*UW-1:0] v, input logic [1:0] i);
    case (i)
      2'd0:    cu = v[UW-1:0];
      2'd1:    cu = v[2*UW-1:UW];
      default: cu = v[3*UW-1:2*UW];
    endcase
  endfunction

  // Point difference a - b, per component
  function automatic logic [3*EW-1:0] vsub(input logic [PT_W-1:0] a,
                                           input logic [PT_W-1:0] b);
    logic [3*EW-1:0] r;
    for (int n = 0; n < 3; n++) begin
      r[n*EW +: EW] = EW'($signed(a[n*COORD_BITS +: COORD_BITS]))
                    - EW'($signed(b[n*COORD_BITS +: COORD_BITS]));
    end
    return r;
  endfunction

  // Edge sum, per component
  function automatic logic [3*MW-1:0] vadd(input logic [3*EW-1:0] a,
                                           input logic [3*EW-1:0] b);
    logic [3*MW-1:0] r;
    for (int n = 0; n < 3; n++) begin
      r[n*MW +: MW] = MW'($signed(a[n*EW +: EW])) + MW'($signed(b[n*EW +: EW]));
    end
    return r;
  endfunction

  // Component pair {ia, ib} for cross terms (steps 0-5) and dot terms (6-8)
  function automatic logic [3:0] xidx(input logic [3:0] k);
    case (k)
      4'd0:    xidx = {2'd1, 2'd2};
      4'd1:    xidx = {2'd2, 2'd1};
      4'd2:    xidx = {2'd2, 2'd0};
      4'd3:    xidx = {2'd0, 2'd2};
      4'd4:    xidx = {2'd0, 2'd1};
      4'd5:    xidx = {2'd1, 2'd0};
      4'd6:    xidx = {2'd0, 2'd0};
      4'd7:    xidx = {2'd1, 2'd1};
      default: xidx = {2'd2, 2'd2};
    endcase
  endfunction

  logic [1:0] gstate;

  // Vector registers
  logic [3*EW-1:0] e0, e1, e2, e3, d0a, d0b, d1a, d1b;
  logic [3*MW-1:0] m1, m2;
  logic [3*NW-1:0] n0, n1;
  logic [3*UW-1:0] u0, u1;
  logic            hit_q, found, found_i, xz, pos0, pos1;

  // Sequencer counters
  logic [1:0] grp, sel, part;
  logic [3:0] k;
  logic       last_op;
  logic [3:0] kmax;
  logic [1:0] smax;

  // Multiply stage
  logic [1:0]              ia, ib;
  logic [3*EW-1:0]         com_edge;
  logic [UW-1:0]           uc;
  logic [NW-1:0]           nc;
  logic signed [OPW-1:0]   op_a, op_b;
  logic                    op_neg, op_clr;
  logic signed [PW-1:0]    prod;
  logic                    q_v, q_neg, q_clr;
  logic [1:0]              q_grp, q_sel, q_part;
  logic [3:0]              q_k;

  // Accumulate stage
  logic signed [ACCW-1:0]  acc, acc_base, acc_next, ext, addend;
  logic                    acc_zero, acc_pos;

  // Corner selection for the edge build
  logic [PT_W-1:0] pcom, f1, f2, s1, s2;

  always_comb begin
    case (cmd.ci)
      2'd0:    begin pcom = p1a; f1 = p1b; f2 = p1c; end
      2'd1:    begin pcom = p1b; f1 = p1a; f2 = p1c; end
      default: begin pcom = p1c; f1 = p1a; f2 = p1b; end
    endcase
    case (cmd.cj)
      2'd0:    begin s1 = p2b; s2 = p2c; end
      2'd1:    begin s1 = p2a; s2 = p2c; end
      default: begin s1 = p2a; s2 = p2b; end
    endcase
  end

  // Edge and centroid vectors, taken at start
  always_ff @(posedge clk) begin
    if (gstate == ST_IDLE && cmd.start) begin
      e0  <= vsub(f1, pcom);
      e1  <= vsub(f2, pcom);
      e2  <= vsub(s1, pcom);
      e3  <= vsub(s2, pcom);
      m1  <= vadd(vsub(f1, pcom), vsub(f2, pcom));
      m2  <= vadd(vsub(s1, pcom), vsub(s2, pcom));
      d0a <= vsub(p1b, p1a);
      d0b <= vsub(p1c, p1a);
      d1a <= vsub(p2b, p2a);
      d1b <= vsub(p2c, p2a);
      hit_q <= cmd.hit;
    end
  end

  assign {ia, ib}  = xidx(k);
  assign com_edge  = found_i ? e1 : e0;
  assign uc        = cu(sel[0] ? u1 : u0, k[1:0]);
  assign nc        = cn(sel[0] ? n1 : n0, k[1:0]);
  assign kmax      = (grp == G_CHK) ? 4'd8 : 4'd5;
  assign smax      = (grp == G_CHK) ? 2'd3 : 2'd1;
  assign last_op   = (grp == G_DOT) && (sel == 2'd1) && (k == 4'd2) && (part == 2'd3);

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (grp)
      G_CHK: begin
        op_a = OPW'(ce(sel[1] ? e1 : e0, ia));
        op_b = OPW'(ce(sel[0] ? e3 : e2, ib));
      end
      G_NRM: begin
        op_a = OPW'(ce(sel[0] ? d1a : d0a, ia));
        op_b = OPW'(ce(sel[0] ? d1b : d0b, ib));
      end
      G_UCR: begin
        if (!sel[0]) begin
          op_a = OPW'(cm(m1, ia));
          op_b = OPW'(ce(com_edge, ib));
        end else begin
          op_a = OPW'(ce(com_edge, ia));
          op_b = OPW'(cm(m2, ib));
        end
      end
      default: begin
        op_a = part[1] ? OPW'($signed(uc[UW-1:HB])) : $signed({{(OPW-HB){1'b0}}, uc[HB-1:0]});
        op_b = part[0] ? OPW'($signed(nc[NW-1:HB])) : $signed({{(OPW-HB){1'b0}}, nc[HB-1:0]});
      end
    endcase
    op_neg = (grp != G_DOT) && (k < 4'd6) && k[0];
    if (grp == G_DOT) op_clr = (k == 4'd0) && (part == 2'd0);
    else if (k < 4'd6) op_clr = !k[0];
    else op_clr = (k == 4'd6);
  end

  // Product register and its control
  always_ff @(posedge clk) begin
    prod   <= op_a * op_b;
    q_neg  <= op_neg;
    q_clr  <= op_clr;
    q_grp  <= grp;
    q_sel  <= sel;
    q_k    <= k;
    q_part <= part;
  end

  // Shifted add into the accumulator
  always_comb begin
    ext = ACCW'(prod);
    case (q_part)
      2'd0:    addend = ext;
      2'd3:    addend = ext <<< (2 * HB);
      default: addend = ext <<< HB;
    endcase
    acc_base = q_clr ? '0 : acc;
    acc_next = q_neg ? acc_base - addend : acc_base + addend;
    acc_zero = (acc_next == '0);
    acc_pos  = !acc_next[ACCW-1] && !acc_zero;
  end

  // Result capture per group
  always_ff @(posedge clk) begin
    if (q_v) begin
      acc <= acc_next;
      case (q_grp)
        G_NRM: begin
          if (q_k[0] && q_k < 4'd6) begin
            if (q_sel[0]) n1[q_k[2:1]*NW +: NW] <= acc_next[NW-1:0];
            else          n0[q_k[2:1]*NW +: NW] <= acc_next[NW-1:0];
          end
        end
        G_UCR: begin
          if (q_k[0] && q_k < 4'd6) begin
            if (q_sel[0]) u1[q_k[2:1]*UW +: UW] <= acc_next[UW-1:0];
            else          u0[q_k[2:1]*UW +: UW] <= acc_next[UW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate  <= ST_IDLE;
      q_v     <= 1'b0;
      found   <= 1'b0;
      found_i <= 1'b0;
      xz      <= 1'b0;
      pos0    <= 1'b0;
      pos1    <= 1'b0;
      grp     <= G_CHK;
      sel     <= '0;
      k       <= '0;
      part    <= '0;
    end else begin
      q_v <= (gstate == ST_RUN);

      // parallel test and sign flags from the accumulate stage
      if (q_v) begin
        if (q_grp == G_CHK) begin
          if (q_k == 4'd1) xz <= acc_zero;
          else if (q_k == 4'd3 || q_k == 4'd5) xz <= xz && acc_zero;
          else if (q_k == 4'd8 && xz && acc_pos) begin
            found   <= 1'b1;
            found_i <= q_sel[1];
          end
        end
        if (q_grp == G_DOT && q_k == 4'd2 && q_part == 2'd3) begin
          if (q_sel[0]) pos1 <= acc_pos;
          else          pos0 <= acc_pos;
        end
      end

      unique case (gstate)
        ST_IDLE: begin
          if (cmd.start) begin
            grp    <= G_CHK;
            sel    <= '0;
            k      <= '0;
            part   <= '0;
            found  <= 1'b0;
            gstate <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (grp == G_DOT) begin
            if (part != 2'd3) part <= part + 2'd1;
            else begin
              part <= '0;
              if (k != 4'd2) k <= k + 4'd1;
              else begin
                k   <= '0;
                sel <= sel + 2'd1;
              end
            end
          end else if (k != kmax) begin
            k <= k + 4'd1;
          end else begin
            k <= '0;
            if (sel != smax) sel <= sel + 2'd1;
            else begin
              sel <= '0;
              grp <= grp + 2'd1;
            end
          end
          if (last_op) gstate <= ST_DRAIN;
        end
        ST_DRAIN: gstate <= ST_FIN;
        ST_FIN:   if (cmd.take) gstate <= ST_IDLE;
        default:  gstate <= ST_IDLE;
      endcase
    end
  end

  // Status back to the controller
  always_comb begin
    sts.done = (gstate == ST_FIN);
    if (!hit_q || !found)  sts.verdict = VERDICT_NONE;
    else if (pos0 == pos1) sts.verdict = VERDICT_SAME;
    else                   sts.verdict = VERDICT_OPPOSITE;
  end

endmodule

/* rtl/adjacent_triangle_orientation_check.sv */
// Load transactions do not occupy the block; a new transaction is taken the next cycle.
// A compare runs from acceptance to a valid verdict through a triangle read, the
// point reads, a setup step, the products on the shared multiplier (one per cycle),
// a drain step and the verdict register, which waits while the result side stalls.
// Input stalls until the verdict is registered. Reset clears control and the output
// valid; both stores are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// adjacent_triangle_orientation_check
// Point and triangle stores in synchronous RAM, a fetch controller that reads
// two triangles and their six corners, and the geometry engine that decides
// whether two triangles share an edge with consistent winding.
// ----------------------------------------------------------------------------
module adjacent_triangle_orientation_check import atoc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [IDX_BITS-1:0]          slot,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [IDX_BITS-1:0]          vertex_a,
  input  logic [IDX_BITS-1:0]          vertex_b,
  input  logic [IDX_BITS-1:0]          vertex_c,
  input  logic [IDX_BITS-1:0]          first_triangle,
  input  logic [IDX_BITS-1:0]          second_triangle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   verdict
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRI   = 3'd1;
  localparam logic [2:0] S_PTS   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_GEOM  = 3'd4;

  logic [2:0]          state;
  logic [1:0]          pc;
  logic                in_acc, take;
  logic [PT_W-1:0]     pt_mem [NUM_POINTS];
  logic [TRI_W-1:0]    tri_mem [NUM_TRIANGLES];
  logic [PT_W-1:0]     pt_rd_a, pt_rd_b;
  logic [TRI_W-1:0]    tri_a, tri_b;
  logic [IDX_BITS-1:0] pa_addr, pb_addr;
  logic [PT_W-1:0]     p1a, p1b, p1c, p2a, p2b, p2c;
  logic                hit;
  logic [1:0]          ci, cj;
  atoc_cmd_t           gcmd;
  atoc_sts_t           gsts;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign take     = !out_valid || !out_stall;

  // Point store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (in_acc && command == CMD_LOAD_POINT) pt_mem[slot] <= {coord_z, coord_y, coord_x};
    pt_rd_a <= pt_mem[pa_addr];
    pt_rd_b <= pt_mem[pb_addr];
  end

  // Triangle store: read only when a compare is taken, so the data holds
  always_ff @(posedge clk) begin
    if (in_acc && command == CMD_LOAD_TRI) tri_mem[slot] <= {vertex_c, vertex_b, vertex_a};
    if (in_acc && command == CMD_COMPARE) begin
      tri_a <= tri_mem[first_triangle];
      tri_b <= tri_mem[second_triangle];
    end
  end

  // Corner address for the current point read
  always_comb begin
    case (pc)
      2'd0: begin
        pa_addr = tri_a[IDX_BITS-1:0];
        pb_addr = tri_b[IDX_BITS-1:0];
      end
      2'd1: begin
        pa_addr = tri_a[2*IDX_BITS-1:IDX_BITS];
        pb_addr = tri_b[2*IDX_BITS-1:IDX_BITS];
      end
      default: begin
        pa_addr = tri_a[3*IDX_BITS-1:2*IDX_BITS];
        pb_addr = tri_b[3*IDX_BITS-1:2*IDX_BITS];
      end
    endcase
  end

  // Corner capture, in the cycle after the read
  always_ff @(posedge clk) begin
    if (state == S_PTS) begin
      case (pc)
        2'd1: begin p1a <= pt_rd_a; p2a <= pt_rd_b; end
        2'd2: begin p1b <= pt_rd_a; p2b <= pt_rd_b; end
        2'd3: begin p1c <= pt_rd_a; p2c <= pt_rd_b; end
        default: ;
      endcase
    end
  end

  // Last shared vertex in loop order
  always_comb begin
    hit = 1'b0;
    ci  = 2'd0;
    cj  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (tri_a[i*IDX_BITS +: IDX_BITS] == tri_b[j*IDX_BITS +: IDX_BITS]) begin
          hit = 1'b1;
          ci  = 2'(i);
          cj  = 2'(j);
        end
      end
    end
  end

  assign gcmd.start = (state == S_START);
  assign gcmd.take  = (state == S_GEOM) && take;
  assign gcmd.hit   = hit;
  assign gcmd.ci    = ci;
  assign gcmd.cj    = cj;

  atoc_geom u_geom (
    .clk (clk),
    .rst (rst),
    .cmd (gcmd),
    .p1a (p1a),
    .p1b (p1b),
    .p1c (p1c),
    .p2a (p2a),
    .p2b (p2b),
    .p2c (p2c),
    .sts (gsts)
  );

  // Fetch controller and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_GEOM && gsts.done && take) out_valid <= 1'b1;
      else if (out_valid && !out_stall)         out_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (in_acc && command == CMD_COMPARE) state <= S_TRI;
        S_TRI: begin
          pc    <= '0;
          state <= S_PTS;
        end
        S_PTS: begin
          pc <= pc + 2'd1;
          if (pc == 2'd3) state <= S_START;
        end
        S_START: state <= S_GEOM;
        S_GEOM: begin
          if (gsts.done && take) begin
            verdict <= gsts.verdict;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/atoc_checker.sv */
// ----------------------------------------------------------------------------
// atoc_port_checks
// Port-level checks for the orientation check block, bound to the top level.
// ----------------------------------------------------------------------------
module atoc_port_checks import atoc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] verdict
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict))
    else $error("stalled result changed");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_NONE || verdict == VERDICT_OPPOSITE ||
                   verdict == VERDICT_SAME))
    else $error("undefined verdict code");

  // A compare occupies the block on the next cycle
  a_cmp_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_COMPARE |=> in_stall)
    else $error("compare did not occupy the block");

  // Reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind adjacent_triangle_orientation_check atoc_port_checks u_atoc_checker (.*);

/* bench/atoc_checker.sv */
// ----------------------------------------------------------------------------
// atoc_checker
// Watches both channels of the triangle orientation block. It mirrors the point
// and triangle stores from the load transactions, computes the verdict of
// every compare transaction with exact wide integers, and checks each result
// in order against the oldest expected verdict.
// ----------------------------------------------------------------------------
module atoc_checker import atoc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [IDX_BITS-1:0]          slot,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [IDX_BITS-1:0]          vertex_a,
  input  logic [IDX_BITS-1:0]          vertex_b,
  input  logic [IDX_BITS-1:0]          vertex_c,
  input  logic [IDX_BITS-1:0]          first_triangle,
  input  logic [IDX_BITS-1:0]          second_triangle,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   verdict,
  output int                           errors,
  output int                           pending
);

  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic signed [127:0] x;
    logic signed [127:0] y;
    logic signed [127:0] z;
  } vec_t;

  // Mirror of the block's stores
  logic signed [COORD_BITS-1:0] mx [NUM_POINTS];
  logic signed [COORD_BITS-1:0] my [NUM_POINTS];
  logic signed [COORD_BITS-1:0] mz [NUM_POINTS];
  logic [IDX_BITS-1:0]          corner [NUM_TRIANGLES][3];

  logic [1:0] verdict_q [$];

  initial begin
    errors  = 0;
    pending = 0;
    for (int k = 0; k < NUM_POINTS; k++) begin
      mx[k] = '0; my[k] = '0; mz[k] = '0;
    end
    for (int k = 0; k < NUM_TRIANGLES; k++) begin
      corner[k][0] = '0; corner[k][1] = '0; corner[k][2] = '0;
    end
  end

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic vec_t point_at(logic [IDX_BITS-1:0] idx);
    vec_t r;
    r.x = wide_t'(mx[idx]); r.y = wide_t'(my[idx]); r.z = wide_t'(mz[idx]);
    return r;
  endfunction

  // Orientation verdict for two stored triangles
  function automatic logic [1:0] orientation_verdict(logic [IDX_BITS-1:0] ta,
                                                     logic [IDX_BITS-1:0] tb);
    vec_t p1 [3];
    vec_t p2 [3];
    vec_t e [4];
    vec_t common, edge_v, m1, m2, n1, n2, xp;
    int ci, cj, cnt, found;
    logic pos1, pos2;
    ci = -1; cj = -1; cnt = 0; found = -1;
    for (int i = 0; i < 3; i++) begin
      p1[i] = point_at(corner[ta][i]);
      p2[i] = point_at(corner[tb][i]);
    end
    // last shared vertex in loop order
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (corner[ta][i] == corner[tb][j]) begin
          ci = i; cj = j;
        end
    if (ci < 0) return VERDICT_NONE;
    common = p1[ci];
    for (int i = 0; i < 3; i++)
      if (i != ci) begin
        e[cnt] = vsub(p1[i], common); cnt++;
      end
    for (int j = 0; j < 3; j++)
      if (j != cj) begin
        e[cnt] = vsub(p2[j], common); cnt++;
      end
    // parallel, same-sense edge pair
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        xp = vcross(e[i], e[2 + j]);
        if (xp.x == 0 && xp.y == 0 && xp.z == 0 && vdot(e[i], e[2 + j]) > 0)
          found = i;
      end
    if (found < 0) return VERDICT_NONE;
    edge_v = e[found];
    // centroid vectors scaled by three
    m1.x = p1[0].x + p1[1].x + p1[2].x - 3 * common.x;
    m1.y = p1[0].y + p1[1].y + p1[2].y - 3 * common.y;
    m1.z = p1[0].z + p1[1].z + p1[2].z - 3 * common.z;
    m2.x = p2[0].x + p2[1].x + p2[2].x - 3 * common.x;
    m2.y = p2[0].y + p2[1].y + p2[2].y - 3 * common.y;
    m2.z = p2[0].z + p2[1].z + p2[2].z - 3 * common.z;
    n1 = vcross(vsub(p1[1], p1[0]), vsub(p1[2], p1[0]));
    n2 = vcross(vsub(p2[1], p2[0]), vsub(p2[2], p2[0]));
    pos1 = vdot(vcross(m1, edge_v), n1) > 0;
    pos2 = vdot(vcross(edge_v, m2), n2) > 0;
    return (pos1 == pos2) ? VERDICT_SAME : VERDICT_OPPOSITE;
  endfunction

  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst) begin
      // result channel first: a result never belongs to this edge's input
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected verdict %0d", verdict);
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want) begin
            errors++;
            if (errors <= 10)
              $display("verdict mismatch: expected %0d, got %0d", want, verdict);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (command)
          CMD_LOAD_POINT: begin
            mx[slot] = coord_x; my[slot] = coord_y; mz[slot] = coord_z;
          end
          CMD_LOAD_TRI: begin
            corner[slot][0] = vertex_a;
            corner[slot][1] = vertex_b;
            corner[slot][2] = vertex_c;
          end
          CMD_COMPARE: verdict_q.push_back(orientation_verdict(first_triangle,
                                                               second_triangle));
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

/* bench/tb_adjacent_triangle_orientation_check.sv */
// ----------------------------------------------------------------------------
// tb_adjacent_triangle_orientation_check
// Drives load and compare transactions into the orientation block: a directed
// set of extreme and degenerate shapes, then random triangle pairs that share
// an edge, random compares and ignored commands, with random idle and stall.
// ----------------------------------------------------------------------------
module tb_adjacent_triangle_orientation_check;
  import atoc_pkg::*;

  localparam int TOTAL_ITEMS = 1850;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [IDX_BITS-1:0] slot = '0;
  logic signed [COORD_BITS-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [IDX_BITS-1:0] vertex_a = '0, vertex_b = '0, vertex_c = '0;
  logic [IDX_BITS-1:0] first_triangle = '0, second_triangle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] verdict;
  int errors, pending;
  int sent = 0;
  int cycles = 0;
  logic quiet = 1'b0;

  // which entries may be read: points written, triangles with written corners
  logic pt_ok [NUM_POINTS];
  logic tri_ok [NUM_TRIANGLES];
  logic [IDX_BITS-1:0] tri_list [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  adjacent_triangle_orientation_check DUT (.*);

  atoc_checker u_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);

  function automatic logic [IDX_BITS-1:0] rnd_idx();
    return IDX_BITS'($urandom);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rnd_coord();
    return COORD_BITS'($urandom);
  endfunction

  // optional idle cycles, then present one transaction on a falling edge
  task automatic open_txn(input logic [1:0] c, input logic [IDX_BITS-1:0] s,
                          input logic signed [COORD_BITS-1:0] x,
                          input logic signed [COORD_BITS-1:0] y,
                          input logic signed [COORD_BITS-1:0] z,
                          input logic [IDX_BITS-1:0] a, input logic [IDX_BITS-1:0] b,
                          input logic [IDX_BITS-1:0] vc, input logic [IDX_BITS-1:0] f,
                          input logic [IDX_BITS-1:0] t);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command <= c; slot <= s; coord_x <= x; coord_y <= y; coord_z <= z;
    vertex_a <= a; vertex_b <= b; vertex_c <= vc;
    first_triangle <= f; second_triangle <= t;
    in_valid <= 1'b1;
  endtask

  task automatic close_txn();
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic load_point(logic [IDX_BITS-1:0] s, logic signed [COORD_BITS-1:0] x,
                            logic signed [COORD_BITS-1:0] y,
                            logic signed [COORD_BITS-1:0] z);
    open_txn(CMD_LOAD_POINT, s, x, y, z, rnd_idx(), rnd_idx(), rnd_idx(),
             rnd_idx(), rnd_idx());
    close_txn();
    pt_ok[s] = 1'b1;
  endtask

  task automatic load_tri(logic [IDX_BITS-1:0] s, logic [IDX_BITS-1:0] a,
                          logic [IDX_BITS-1:0] b, logic [IDX_BITS-1:0] c);
    open_txn(CMD_LOAD_TRI, s, rnd_coord(), rnd_coord(), rnd_coord(), a, b, c,
             rnd_idx(), rnd_idx());
    close_txn();
    tri_ok[s] = pt_ok[a] && pt_ok[b] && pt_ok[c];
    if (tri_ok[s]) tri_list.push_back(s);
  endtask

  task automatic compare_tris(logic [IDX_BITS-1:0] f, logic [IDX_BITS-1:0] s);
    open_txn(CMD_COMPARE, rnd_idx(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_idx(), rnd_idx(), rnd_idx(), f, s);
    close_txn();
  endtask

  task automatic unused_cmd();
    open_txn(CMD_UNUSED, rnd_idx(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_idx(), rnd_idx(), rnd_idx(), rnd_idx(), rnd_idx());
    close_txn();
  endtask

  // mostly small coordinates so edges line up often, some full range
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 60) return COORD_BITS'(int'($urandom_range(6)) - 3);
    if (r < 85) return rnd_coord();
    case ($urandom_range(2))
      0: return CMAX;
      1: return CMIN;
      default: return '0;
    endcase
  endfunction

  // two triangles sharing points p0 and p1, corners in random order
  task automatic shared_edge_pair();
    logic [IDX_BITS-1:0] p [4];
    logic [IDX_BITS-1:0] q [3];
    logic [IDX_BITS-1:0] t1, t2, tmp;
    int k;
    for (int i = 0; i < 4; i++) begin
      p[i] = rnd_idx();
      load_point(p[i], pick_coord(), pick_coord(), pick_coord());
    end
    t1 = rnd_idx();
    t2 = rnd_idx();
    if ($urandom_range(1)) load_tri(t1, p[0], p[1], p[2]);
    else load_tri(t1, p[1], p[0], p[2]);
    q[0] = p[0]; q[1] = p[1]; q[2] = p[3];
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = q[i]; q[i] = q[k]; q[k] = tmp;
    end
    load_tri(t2, q[0], q[1], q[2]);
    if (!tri_ok[t1]) load_tri(t1, p[0], p[1], p[2]);
    if ($urandom_range(1)) compare_tris(t1, t2);
    else compare_tris(t2, t1);
  endtask

  initial begin
    logic [IDX_BITS-1:0] f, s;
    int r;
    for (int k = 0; k < NUM_POINTS; k++) pt_ok[k] = 1'b0;
    for (int k = 0; k < NUM_TRIANGLES; k++) tri_ok[k] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, shared edges both ways, degenerate shapes
    load_point(0, 0, 0, 0);
    load_point(4095, CMAX, CMAX, CMAX);
    load_point(1, CMIN, CMIN, CMIN);
    load_point(2, 1, 0, 0);
    load_point(3, 0, 1, 0);
    load_point(4, 0, 0, 1);
    load_point(5, 0, -1, 0);
    load_point(6, 0, 0, 0);
    load_tri(0, 0, 2, 3);
    load_tri(1, 2, 0, 5);
    load_tri(2, 0, 3, 2);
    load_tri(3, 0, 4095, 1);
    load_tri(4095, 0, 0, 2);
    load_tri(5, 2, 3, 4);
    load_tri(6, 0, 6, 2);
    compare_tris(0, 1);
    compare_tris(1, 0);
    compare_tris(0, 2);
    compare_tris(0, 3);
    compare_tris(3, 4095);
    compare_tris(4095, 0);
    compare_tris(0, 0);
    compare_tris(5, 0);
    compare_tris(6, 0);
    unused_cmd();

    // random: mostly well-formed shared-edge pairs, plus noise
    while (sent < TOTAL_ITEMS) begin
      quiet = (sent >= 400 && sent < 700);
      if (sent >= 1000 && sent < 1010) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      r = $urandom_range(99);
      if (r < 60) shared_edge_pair();
      else if (r < 75) begin
        f = tri_list[$urandom_range(tri_list.size() - 1)];
        s = tri_list[$urandom_range(tri_list.size() - 1)];
        if (tri_ok[f] && tri_ok[s]) compare_tris(f, s);
      end else if (r < 85) load_point(rnd_idx(), pick_coord(), pick_coord(), pick_coord());
      else if (r < 95) load_tri(rnd_idx(), rnd_idx(), rnd_idx(), rnd_idx());
      else unused_cmd();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
